// ----- rtl/bmrc_pkg.sv -----
package bmrc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_UNCLOSED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_ANGLE  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_CURLY  = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } bracket_t;

    // Classify an opening bracket.
    function automatic bracket_t open_kind(input logic [7:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (c)
            8'd40:   b.kind = KIND_PAREN;
            8'd60:   b.kind = KIND_ANGLE;
            8'd91:   b.kind = KIND_SQUARE;
            8'd123:  b.kind = KIND_CURLY;
            default: b.hit  = 1'b0;
        endcase
        return b;
    endfunction

    // Classify a closing bracket.
    function automatic bracket_t close_kind(input logic [7:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (c)
            8'd41:   b.kind = KIND_PAREN;
            8'd62:   b.kind = KIND_ANGLE;
            8'd93:   b.kind = KIND_SQUARE;
            8'd125:  b.kind = KIND_CURLY;
            default: b.hit  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/bracket_match_replace_counter_unit.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_ch[7:0], s_last
// m_        out        m_valid / m_ready  m_replacements[15:0], m_status[1:0], m_final_res
//
// One word per cycle while s_ready is high: each character updates the state and lands in the
// result register in the same cycle.
// The top of the bracket stack lives in a register; the entry below it is
// kept prefetched from the stack RAM, so push and pop need no extra RAM read.
// Reset (aresetn low, synchronous) clears level, count, error and m_valid.
// The stack RAM is not cleared; entries are only used after being written.
// s_ready is high while the result register is empty or being drained.
module bracket_match_replace_counter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_replacements,
    output logic [1:0]  m_status,
    output logic        m_final_res
);

    // Stack state: level counts held openers, tos_reg holds the top entry.
    logic [bmrc_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [1:0]                   tos_reg, tos_next;
    logic [bmrc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [1:0]                   err_reg, err_next;

    logic                         m_valid_reg;
    logic [bmrc_pkg::COUNT_W-1:0] m_repl_reg, m_repl_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic                         m_final_reg;

    logic                         accept;
    bmrc_pkg::bracket_t           opener, closer;

    // RAM side: every push is written at the current level; the read port
    // continuously fetches the entry just under the (next) top of stack.
    logic                         ram_we;
    logic [bmrc_pkg::ADDR_W-1:0]  ram_waddr;
    logic [bmrc_pkg::ADDR_W-1:0]  ram_raddr;
    logic [bmrc_pkg::LEVEL_W-1:0] under_level;
    logic [1:0]                   under_data;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign opener = bmrc_pkg::open_kind(s_ch);
    assign closer = bmrc_pkg::close_kind(s_ch);

    assign ram_waddr = level_reg[bmrc_pkg::ADDR_W-1:0];

    always_comb begin
        level_next    = level_reg;
        tos_next      = tos_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        ram_we        = 1'b0;
        m_repl_next   = count_reg;
        m_status_next = err_reg;

        if (accept) begin
            // Process the character unless an error has latched.
            if (err_reg == bmrc_pkg::ST_OK) begin
                if (opener.hit) begin
                    if (level_reg == bmrc_pkg::LEVEL_W'(bmrc_pkg::STACK_DEPTH)) begin
                        err_next = bmrc_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we     = 1'b1;
                        tos_next   = opener.kind;
                        level_next = level_reg + bmrc_pkg::LEVEL_W'(1);
                    end
                end else if (closer.hit) begin
                    if (level_reg == '0) begin
                        err_next = bmrc_pkg::ST_EMPTY;
                    end else begin
                        // Pop: the prefetched entry below becomes the new top.
                        tos_next   = under_data;
                        level_next = level_reg - bmrc_pkg::LEVEL_W'(1);
                        if (tos_reg != closer.kind && count_reg != bmrc_pkg::COUNT_MAX) begin
                            count_next = count_reg + bmrc_pkg::COUNT_W'(1);
                        end
                    end
                end
            end

            m_repl_next   = count_next;
            m_status_next = err_next;
            if (s_last && err_next == bmrc_pkg::ST_OK && level_next != '0) begin
                m_status_next = bmrc_pkg::ST_UNCLOSED;
            end

            // Drop all string state after the verdict.
            if (s_last) begin
                level_next = '0;
                count_next = '0;
                err_next   = bmrc_pkg::ST_OK;
            end
        end
    end

    assign under_level = level_next - bmrc_pkg::LEVEL_W'(2);
    assign ram_raddr   = under_level[bmrc_pkg::ADDR_W-1:0];

    bmrc_ram #(
        .WIDTH (2),
        .DEPTH (bmrc_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (opener.kind),
        .rd_addr (ram_raddr),
        .rd_data (under_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= '0;
            count_reg   <= '0;
            err_reg     <= bmrc_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            level_reg <= level_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next accepted word.
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (accept) begin
            m_repl_reg   <= m_repl_next;
            m_status_reg <= m_status_next;
            m_final_reg  <= s_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_replacements = m_repl_reg;
    assign m_status       = m_status_reg;
    assign m_final_res    = m_final_reg;

    // Level never exceeds the stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= bmrc_pkg::LEVEL_W'(bmrc_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    // A final word clears the string state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last |=> level_reg == '0 && count_reg == '0
                             && err_reg == bmrc_pkg::ST_OK)
        else $error("state not cleared after final word");

    // A latched error holds through non-final words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_last && err_reg != bmrc_pkg::ST_OK |=> $stable(err_reg))
        else $error("latched error changed");

    // Unclosed status only appears on a verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == bmrc_pkg::ST_UNCLOSED |-> m_final_reg)
        else $error("unclosed status on non-final result");

endmodule

// ----- rtl/bmrc_ram.sv -----
module bmrc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
